>>> rtl/tsg_pkg.sv
// Package for the triangle span generator: sequencer states, function codes
// and fixed field widths. No dependencies.

package tsg_pkg;

    localparam int IN_W  = 12;
    localparam int OUT_W = 12;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SETPH,
        ST_DIVS_GO,
        ST_DIVS_WAIT,
        ST_DIVL_GO,
        ST_DIVL_WAIT,
        ST_FINISH
    } tsg_state_t;

endpackage

>>> rtl/tsg_sort.sv
// Three-vertex sort by y for the triangle span generator: three
// compare-exchange steps, equal y keeps input order. No dependencies.

module tsg_sort #(
    parameter int W = 12
) (
    input  logic [W-1:0] ax,
    input  logic [W-1:0] ay,
    input  logic [W-1:0] bx,
    input  logic [W-1:0] by,
    input  logic [W-1:0] cx,
    input  logic [W-1:0] cy,
    output logic [W-1:0] x0,
    output logic [W-1:0] y0,
    output logic [W-1:0] x1,
    output logic [W-1:0] y1,
    output logic [W-1:0] x2,
    output logic [W-1:0] y2
);

    logic [W-1:0] p_ax, p_ay, p_bx, p_by;
    logic [W-1:0] q_bx, q_by;

    always_comb
    begin
        // first pass: a against b
        if (ay > by)
        begin
            p_ax = bx; p_ay = by; p_bx = ax; p_by = ay;
        end
        else
        begin
            p_ax = ax; p_ay = ay; p_bx = bx; p_by = by;
        end
        // second pass: b against c
        if (p_by > cy)
        begin
            q_bx = cx;   q_by = cy;   x2 = p_bx; y2 = p_by;
        end
        else
        begin
            q_bx = p_bx; q_by = p_by; x2 = cx;   y2 = cy;
        end
        // third pass: a against b again
        if (p_ay > q_by)
        begin
            x0 = q_bx; y0 = q_by; x1 = p_ax; y1 = p_ay;
        end
        else
        begin
            x0 = p_ax; y0 = p_ay; x1 = q_bx; y1 = q_by;
        end
    end

endmodule

>>> rtl/tsg_div.sv
// Shared restoring divider for the triangle span generator: signed numerator,
// non-negative denominator, quotient truncated toward zero, one bit a cycle.
// Zero denominator gives a zero quotient. No dependencies.

module tsg_div #(
    parameter int W = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [2*W:0] num,
    input  logic [W-1:0]        den,
    output logic                done,
    output logic signed [W:0]   quot
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          zero_reg, zero_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;

    logic [2*W:0]  mag;
    logic [W:0]    sh;
    logic [W:0]    diff;
    logic          ge;
    logic signed [W:0] quo_pos;

    assign mag  = num[2*W] ? (2*W+1)'(-num) : num;
    assign sh   = {rem_reg, quo_reg[W-1]};
    assign diff = sh - {1'b0, den_reg};
    assign ge   = (sh >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // the quotient always fits W bits, so the high half starts below den
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            neg_next  = num[2*W];
            zero_next = (den == '0);
            den_next  = den;
            rem_next  = mag[2*W-1:W];
            quo_next  = mag[W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[W-1:0] : sh[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign quo_pos = $signed({1'b0, quo_reg});
    assign done    = done_reg;
    assign quot    = zero_reg ? '0 : (neg_reg ? -quo_pos : quo_pos);

endmodule

>>> rtl/triangle_span_generator_unit.sv
// Triangle span generator top level: sequencer, edge accumulators, output word.
// Depends on tsg_pkg, tsg_sort and tsg_div. A load word is taken without leaving ST_IDLE.
// For each span the shared divider runs twice, one quotient bit a cycle; the row that opens
// the second segment first passes through ST_SETPH.
// An empty or flat span is written from ST_START with no division; a held output word stalls.
// Reset (rst_n, asynchronous, active low) leaves no triangle active and no word pending.

module triangle_span_generator_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic [tsg_pkg::IN_W-1:0] vertex_a_x,
    input  logic [tsg_pkg::IN_W-1:0] vertex_a_y,
    input  logic [tsg_pkg::IN_W-1:0] vertex_b_x,
    input  logic [tsg_pkg::IN_W-1:0] vertex_b_y,
    input  logic [tsg_pkg::IN_W-1:0] vertex_c_x,
    input  logic [tsg_pkg::IN_W-1:0] vertex_c_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tsg_pkg::OUT_W-1:0] span_y,
    output logic [tsg_pkg::OUT_W-1:0] span_left,
    output logic [tsg_pkg::OUT_W-1:0] span_right,
    output logic                      last_span,
    output logic                      no_span
);

    import tsg_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int ACC_W = 2 * W + 1;
    localparam int E_W   = W + 2;

    tsg_state_t state_reg, state_next;

    logic [W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [W-1:0] x0_next, y0_next, x1_next, y1_next, x2_next, y2_next;
    logic [W-1:0] row_reg, row_next;
    logic signed [W:0] fse_reg, fse_next;
    logic signed [ACC_W-1:0] short_reg, short_next;
    logic signed [ACC_W-1:0] long_reg, long_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [W:0] qs_reg, qs_next;
    logic signed [W:0] ql_reg, ql_next;
    logic phase_reg, phase_next;
    logic active_reg, active_next;
    logic flat_reg, flat_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] span_y_reg, span_y_next;
    logic [OUT_W-1:0] span_left_reg, span_left_next;
    logic [OUT_W-1:0] span_right_reg, span_right_next;
    logic             last_span_reg, last_span_next;
    logic             no_span_reg, no_span_next;

    logic [W-1:0] sx0, sy0, sx1, sy1, sx2, sy2;
    logic         in_take;
    logic         out_free;

    logic                    div_start;
    logic signed [ACC_W-1:0] div_num;
    logic [W-1:0]            div_den;
    logic                    div_done;
    logic signed [W:0]       div_quot;

    logic signed [W:0]     dx10, dx21, dx20, dyr;
    logic signed [2*W+1:0] mul_full;
    logic signed [E_W-1:0] edge_a, edge_b, span_lo, span_hi;
    logic [W-1:0]          flat_min, flat_max;

    tsg_sort #(.W(W)) u_sort (
        .ax (W'(vertex_a_x)),
        .ay (W'(vertex_a_y)),
        .bx (W'(vertex_b_x)),
        .by (W'(vertex_b_y)),
        .cx (W'(vertex_c_x)),
        .cy (W'(vertex_c_y)),
        .x0 (sx0),
        .y0 (sy0),
        .x1 (sx1),
        .y1 (sy1),
        .x2 (sx2),
        .y2 (sy2)
    );

    assign div_start = (state_reg == ST_DIVS_GO) || (state_reg == ST_DIVL_GO);
    assign div_num   = (state_reg == ST_DIVS_GO) ? short_reg : long_reg;
    assign div_den   = (state_reg == ST_DIVL_GO) ? (y2_reg - y0_reg) :
                       (phase_reg ? (y2_reg - y1_reg) : (y1_reg - y0_reg));

    tsg_div #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign dx10     = $signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg});
    assign dx21     = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
    assign dx20     = $signed({1'b0, x2_reg}) - $signed({1'b0, x0_reg});
    assign dyr      = $signed({1'b0, row_reg - y1_reg});
    assign mul_full = dx21 * dyr;

    assign edge_a  = $signed({2'b00, (phase_reg ? x1_reg : x0_reg)}) + E_W'(qs_reg);
    assign edge_b  = $signed({2'b00, x0_reg}) + E_W'(ql_reg);
    assign span_lo = (edge_a > edge_b) ? edge_b : edge_a;
    assign span_hi = (edge_a > edge_b) ? edge_a : edge_b;

    always_comb
    begin
        flat_min = x0_reg;
        flat_max = x0_reg;
        if (x1_reg < flat_min) flat_min = x1_reg;
        if (x1_reg > flat_max) flat_max = x1_reg;
        if (x2_reg < flat_min) flat_min = x2_reg;
        if (x2_reg > flat_max) flat_max = x2_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        x2_next         = x2_reg;
        y2_next         = y2_reg;
        row_next        = row_reg;
        fse_next        = fse_reg;
        short_next      = short_reg;
        long_next       = long_reg;
        prod_next       = prod_reg;
        qs_next         = qs_reg;
        ql_next         = ql_reg;
        phase_next      = phase_reg;
        active_next     = active_reg;
        flat_next       = flat_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        span_y_next     = span_y_reg;
        span_left_next  = span_left_reg;
        span_right_next = span_right_reg;
        last_span_next  = last_span_reg;
        no_span_next    = no_span_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        x0_next     = sx0;
                        y0_next     = sy0;
                        x1_next     = sx1;
                        y1_next     = sy1;
                        x2_next     = sx2;
                        y2_next     = sy2;
                        flat_next   = (sy0 == sy2);
                        fse_next    = (sy1 == sy2) ? $signed({1'b0, sy1}) :
                                      $signed({1'b0, sy1}) - (W+1)'(1);
                        row_next    = sy0;
                        short_next  = '0;
                        long_next   = '0;
                        phase_next  = 1'b0;
                        active_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end

            ST_START:
            begin
                if (!active_reg || flat_reg)
                begin
                    // hold until the output word is free
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        no_span_next    = !active_reg;
                        last_span_next  = active_reg;
                        span_y_next     = active_reg ? OUT_W'(y0_reg) : '0;
                        span_left_next  = active_reg ? OUT_W'(flat_min) : '0;
                        span_right_next = active_reg ? OUT_W'(flat_max) : '0;
                        active_next     = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!phase_reg && ($signed({1'b0, row_reg}) > fse_reg))
                begin
                    prod_next  = mul_full[ACC_W-1:0];
                    state_next = ST_SETPH;
                end
                else
                begin
                    state_next = ST_DIVS_GO;
                end
            end

            ST_SETPH:
            begin
                // restart the short edge from vertex 1
                short_next = prod_reg;
                phase_next = 1'b1;
                state_next = ST_DIVS_GO;
            end

            ST_DIVS_GO:
            begin
                state_next = ST_DIVS_WAIT;
            end

            ST_DIVS_WAIT:
            begin
                if (div_done)
                begin
                    qs_next    = div_quot;
                    state_next = ST_DIVL_GO;
                end
            end

            ST_DIVL_GO:
            begin
                state_next = ST_DIVL_WAIT;
            end

            ST_DIVL_WAIT:
            begin
                if (div_done)
                begin
                    ql_next    = div_quot;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    no_span_next    = 1'b0;
                    last_span_next  = (row_reg >= y2_reg);
                    span_y_next     = OUT_W'(row_reg);
                    span_left_next  = OUT_W'(span_lo);
                    span_right_next = OUT_W'(span_hi);
                    short_next      = short_reg + ACC_W'(phase_reg ? dx21 : dx10);
                    long_next       = long_reg + ACC_W'(dx20);
                    if (row_reg >= y2_reg)
                        active_next = 1'b0;
                    else
                        row_next = row_reg + W'(1);
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            flat_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            flat_reg      <= flat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        x2_reg         <= x2_next;
        y2_reg         <= y2_next;
        row_reg        <= row_next;
        fse_reg        <= fse_next;
        short_reg      <= short_next;
        long_reg       <= long_next;
        prod_reg       <= prod_next;
        qs_reg         <= qs_next;
        ql_reg         <= ql_next;
        span_y_reg     <= span_y_next;
        span_left_reg  <= span_left_next;
        span_right_reg <= span_right_next;
        last_span_reg  <= last_span_next;
        no_span_reg    <= no_span_next;
    end

    assign out_valid  = out_valid_reg;
    assign span_y     = span_y_reg;
    assign span_left  = span_left_reg;
    assign span_right = span_right_reg;
    assign last_span  = last_span_reg;
    assign no_span    = no_span_reg;

endmodule

>>> verif/tb.sv
// Self-checking bench for triangle_span_generator_unit: a scoreboard class predicts every span
// from the load and next words that the block takes, and checks each output word in order.
// Depends on tsg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import tsg_pkg::*;

    localparam int IDLE_PCT       = 34;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int RANDOM_WORDS   = 850;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 40;

    typedef struct {
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] right;
        logic             last;
        logic             none;
    } span_t;

    class span_scoreboard;
        int    vx[3];
        int    vy[3];
        int    row;
        int    seg_end;
        int    short_acc;
        int    long_acc;
        bit    phase;
        bit    active;
        bit    flat;
        span_t spans_due[$];
        int    errors;
        int    spans_seen;

        function int pending();
            return spans_due.size();
        endfunction

        // signed quotient truncated toward zero; a zero divisor gives zero
        function int edge_div(int n, int d);
            return (d == 0) ? 0 : n / d;
        endfunction

        function void note_word(logic f, logic [IN_W-1:0] ax, logic [IN_W-1:0] ay,
                                logic [IN_W-1:0] bx, logic [IN_W-1:0] by,
                                logic [IN_W-1:0] cx, logic [IN_W-1:0] cy);
            span_t s;
            int    a;
            int    b;
            int    t;
            int    i;
            int    j;
            s = '{default: '0};
            if (f == FUNC_LOAD) begin
                vx = '{int'(ax), int'(bx), int'(cx)};
                vy = '{int'(ay), int'(by), int'(cy)};
                // stable three-step sort by y: (0,1), (1,2), (0,1)
                for (int k = 0; k < 3; k++) begin
                    i = (k == 1) ? 1 : 0;
                    j = i + 1;
                    if (vy[i] > vy[j]) begin
                        t = vx[i]; vx[i] = vx[j]; vx[j] = t;
                        t = vy[i]; vy[i] = vy[j]; vy[j] = t;
                    end
                end
                flat      = (vy[0] == vy[2]);
                seg_end   = (vy[1] == vy[2]) ? vy[1] : vy[1] - 1;
                row       = vy[0];
                short_acc = 0;
                long_acc  = 0;
                phase     = 1'b0;
                active    = 1'b1;
                return;
            end
            if (!active) begin
                s.none = 1'b1;
            end
            else if (flat) begin
                a = vx[0];
                b = vx[0];
                for (i = 1; i < 3; i++) begin
                    if (vx[i] < a) a = vx[i];
                    if (vx[i] > b) b = vx[i];
                end
                s.y     = vy[0][OUT_W-1:0];
                s.left  = a[OUT_W-1:0];
                s.right = b[OUT_W-1:0];
                s.last  = 1'b1;
                active  = 1'b0;
            end
            else begin
                // open the second segment on the first row past the first one
                if (!phase && row > seg_end) begin
                    phase     = 1'b1;
                    short_acc = (vx[2] - vx[1]) * (row - vy[1]);
                end
                if (!phase) begin
                    a = vx[0] + edge_div(short_acc, vy[1] - vy[0]);
                    short_acc += vx[1] - vx[0];
                end
                else begin
                    a = vx[1] + edge_div(short_acc, vy[2] - vy[1]);
                    short_acc += vx[2] - vx[1];
                end
                b = vx[0] + edge_div(long_acc, vy[2] - vy[0]);
                long_acc += vx[2] - vx[0];
                if (a > b) begin
                    t = a; a = b; b = t;
                end
                s.y     = row[OUT_W-1:0];
                s.left  = a[OUT_W-1:0];
                s.right = b[OUT_W-1:0];
                s.last  = (row >= vy[2]);
                if (s.last) active = 1'b0;
                else        row++;
            end
            spans_due.push_back(s);
        endfunction

        task report_mismatch(string what, int got, int want);
            if (errors < MAX_REPORTS)
                $display("span %0d: %s is %0d, want %0d", spans_seen, what, got, want);
            errors++;
        endtask

        task check_span(logic [OUT_W-1:0] y, logic [OUT_W-1:0] left,
                        logic [OUT_W-1:0] right, logic last, logic none);
            span_t s;
            spans_seen++;
            if (spans_due.size() == 0) begin
                report_mismatch("unexpected word, count", spans_seen, spans_seen - 1);
                return;
            end
            s = spans_due.pop_front();
            if (y !== s.y)         report_mismatch("span_y", y, s.y);
            if (left !== s.left)   report_mismatch("span_left", left, s.left);
            if (right !== s.right) report_mismatch("span_right", right, s.right);
            if (last !== s.last)   report_mismatch("last_span", last, s.last);
            if (none !== s.none)   report_mismatch("no_span", none, s.none);
        endtask
    endclass

    logic             clk;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_ready;
    logic             func       = FUNC_NEXT;
    logic [IN_W-1:0]  vertex_a_x = '0;
    logic [IN_W-1:0]  vertex_a_y = '0;
    logic [IN_W-1:0]  vertex_b_x = '0;
    logic [IN_W-1:0]  vertex_b_y = '0;
    logic [IN_W-1:0]  vertex_c_x = '0;
    logic [IN_W-1:0]  vertex_c_y = '0;
    logic             out_valid;
    logic             out_ready  = 1'b0;
    logic [OUT_W-1:0] span_y;
    logic [OUT_W-1:0] span_left;
    logic [OUT_W-1:0] span_right;
    logic             last_span;
    logic             no_span;

    span_scoreboard sb = new();
    bit             quiet    = 1'b0;
    bit             hold_req = 1'b0;
    int             words_sent;
    int             cycle_count;

    triangle_span_generator_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .vertex_a_x (vertex_a_x),
        .vertex_a_y (vertex_a_y),
        .vertex_b_x (vertex_b_x),
        .vertex_b_y (vertex_b_y),
        .vertex_c_x (vertex_c_x),
        .vertex_c_y (vertex_c_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_y     (span_y),
        .span_left  (span_left),
        .span_right (span_right),
        .last_span  (last_span),
        .no_span    (no_span)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_word(func, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                         vertex_c_x, vertex_c_y);
        if (rst_n && out_valid && out_ready)
            sb.check_span(span_y, span_left, span_right, last_span, no_span);
    end

    // receiver: random back-pressure, or one long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else begin
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(logic f, logic [IN_W-1:0] ax, logic [IN_W-1:0] ay,
                             logic [IN_W-1:0] bx, logic [IN_W-1:0] by,
                             logic [IN_W-1:0] cx, logic [IN_W-1:0] cy);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        vertex_a_x <= ax;
        vertex_a_y <= ay;
        vertex_b_x <= bx;
        vertex_b_y <= by;
        vertex_c_x <= cx;
        vertex_c_y <= cy;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // vertex fields are ignored on a next word, so fill them with noise
    task automatic ask_span();
        send_word(FUNC_NEXT, IN_W'($urandom_range(4095)), IN_W'($urandom_range(4095)),
                  IN_W'($urandom_range(4095)), IN_W'($urandom_range(4095)),
                  IN_W'($urandom_range(4095)), IN_W'($urandom_range(4095)));
    endtask

    // drop valid so the last accepted word is noted before counting
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic random_triangle();
        int xs[3];
        int ys[3];
        int h;
        int base;
        int r;
        int take;
        int i;
        int j;
        int t;
        bit noise;
        r     = $urandom_range(99);
        noise = ($urandom_range(99) < 5);
        if (r < 55)      h = $urandom_range(6);
        else if (r < 85) h = $urandom_range(24, 7);
        else if (r < 97) h = $urandom_range(64, 25);
        else             h = $urandom_range(200, 65);
        base = $urandom_range(4095 - h);
        for (i = 0; i < 3; i++) xs[i] = $urandom_range(4095);
        ys[0] = base;
        ys[1] = base + h;
        ys[2] = base + $urandom_range(h);
        for (i = 0; i < 3; i++)
        begin
            j = $urandom_range(2);
            t = ys[i]; ys[i] = ys[j]; ys[j] = t;
        end
        if (noise)
            for (i = 0; i < 3; i++) ys[i] = $urandom_range(4095);
        send_word(FUNC_LOAD, IN_W'(xs[0]), IN_W'(ys[0]), IN_W'(xs[1]), IN_W'(ys[1]),
                  IN_W'(xs[2]), IN_W'(ys[2]));
        if (noise)
            take = $urandom_range(5, 1);
        else if ($urandom_range(99) < 10)
            take = $urandom_range(h);
        else
            take = h + 1 + ($urandom_range(99) < 20);
        repeat (take) ask_span();
    endtask

    initial
    begin
        bit pressed;
        pressed    = 1'b0;
        words_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing loaded yet
        ask_span();
        // all on one row, x at both extremes
        send_word(FUNC_LOAD, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd2048, 12'd0);
        repeat (2) ask_span();
        // bottom rows, final span on the last row
        send_word(FUNC_LOAD, 12'd0, 12'd4095, 12'd4095, 12'd4093, 12'd100, 12'd4094);
        repeat (3) ask_span();
        // empty first segment: top two vertices share a row
        send_word(FUNC_LOAD, 12'd10, 12'd20, 12'd50, 12'd20, 12'd30, 12'd23);
        repeat (4) ask_span();
        // flat bottom: lower two vertices share a row
        send_word(FUNC_LOAD, 12'd30, 12'd5, 12'd10, 12'd9, 12'd60, 12'd9);
        repeat (5) ask_span();
        // full-height triangle, cut short by the next load
        send_word(FUNC_LOAD, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd2048, 12'd1000);
        repeat (3) ask_span();

        while (words_sent < 23 + RANDOM_WORDS)
        begin
            quiet = (words_sent > 350 && words_sent < 500);
            if (!pressed && words_sent > 200) begin
                // fill the block while the receiver holds off, then let it drain
                pressed = 1'b1;
                send_word(FUNC_LOAD, 12'd100, 12'd500, 12'd3000, 12'd540, 12'd1500, 12'd560);
                hold_req = 1'b1;
                repeat (61) ask_span();
                wait_drained();
            end
            random_triangle();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
